@@ src/radial_profile_averager_top_assert.svh @@
// Assertion macros shared by the radial profile averager RTL.
`ifndef RADIAL_PROFILE_AVERAGER_TOP_ASSERT_SVH
`define RADIAL_PROFILE_AVERAGER_TOP_ASSERT_SVH
// Implication checked every clock edge outside reset.
`define RPA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define RPA_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ src/rpa_pkg.sv @@
// ----------------------------------------------------------------------------
// rpa_pkg
// Types and constants for the radial profile averager.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package rpa_pkg;
    localparam int MAX_BINS_DEF = 64;
    localparam int CNT_W  = 20;
    localparam int SUM_W  = 52;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic signed [31:0] MEAN_FLOOR = 32'sd7;
    localparam logic [1:0] REG_CENTER_X = 2'd0;
    localparam logic [1:0] REG_CENTER_Y = 2'd1;
    localparam logic [1:0] REG_BIN_WIDTH = 2'd2;
    localparam logic [1:0] REG_BINS_IN_USE = 2'd3;

    typedef struct packed {
        logic signed [31:0] node_x;
        logic signed [31:0] node_y;
        logic signed [31:0] node_z;
        logic               last_node;
    } rpa_in_t;

    typedef struct packed {
        logic [5:0]         bin_index;
        logic [19:0]        node_count;
        logic signed [31:0] mean_z;
        logic               last_bin;
    } rpa_out_t;
endpackage

@@ src/rpa_div.sv @@
// ----------------------------------------------------------------------------
// rpa_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rpa_div #(
    parameter int W = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic [W-1:0] quotient,
    output logic         busy,
    output logic         done
);
    localparam int CW = $clog2(W + 1);
    logic [W-1:0]  q_reg, q_next;
    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next, done_reg, done_next;
    logic [W:0]    trial;

    // One shift-subtract step per cycle
    always_comb begin
        q_next = q_reg; rem_next = rem_reg; d_next = d_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; done_next = 1'b0;
        trial = '0;
        if (start) begin
            q_next = dividend; rem_next = '0; d_next = divisor;
            cnt_next = CW'(W); busy_next = 1'b1;
        end else if (busy_reg) begin
            trial = {rem_reg[W-1:0], q_reg[W-1]} - {1'b0, d_reg};
            if (!trial[W]) begin
                rem_next = trial;
                q_next = {q_reg[W-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[W-1:0], q_reg[W-1]};
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0; done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0; done_reg <= 1'b0; cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next; done_reg <= done_next; cnt_reg <= cnt_next;
        end
        q_reg <= q_next; rem_reg <= rem_next; d_reg <= d_next;
    end

    assign quotient = q_reg;
    assign busy = busy_reg;
    assign done = done_reg;
endmodule

@@ src/radial_profile_averager_top.sv @@
// ----------------------------------------------------------------------------
// radial_profile_averager_top
// Bins surface points by radial distance and emits per-bin mean heights.
// ----------------------------------------------------------------------------
// A point is accepted only in idle, and the next one is not taken until it is
// done: a 33-step square root, then a 64-step division by the bin width in
// the shared divider, then a read-modify-write of the bin memories. A point
// marked last then scans all MAX_BINS entries, each non-empty bin taking a
// 64-step division for its mean, and clears each entry as it goes. The
// divider sets the rate. Bin memories are cleared by a sweep over all
// MAX_BINS entries after reset, during which no point is accepted.
`timescale 1ns / 1ps
module radial_profile_averager_top #(
    parameter int MAX_BINS = rpa_pkg::MAX_BINS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rpa_pkg::rpa_in_t     s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rpa_pkg::rpa_out_t    m_data
);
    import rpa_pkg::*;
    `include "radial_profile_averager_top_assert.svh"

    localparam int AW = $clog2(MAX_BINS);
    localparam logic [6:0] MAXB7 = 7'(MAX_BINS);

    localparam logic [3:0] ST_CLR   = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_SQRT  = 4'd2;
    localparam logic [3:0] ST_DIVK  = 4'd3;
    localparam logic [3:0] ST_WAITK = 4'd4;
    localparam logic [3:0] ST_UPD   = 4'd5;
    localparam logic [3:0] ST_SRD   = 4'd6;
    localparam logic [3:0] ST_SCHK  = 4'd7;
    localparam logic [3:0] ST_SDIV  = 4'd8;
    localparam logic [3:0] ST_SOUT  = 4'd9;
    localparam logic [3:0] ST_RD    = 4'd10;

    // Configuration registers
    logic signed [31:0] cx_reg, cy_reg;
    logic [30:0] bw_reg;
    logic [6:0]  nb_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg <= '0; cy_reg <= '0; bw_reg <= 31'd65536; nb_reg <= 7'd64;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_CENTER_X:    cx_reg <= cfg_data;
                REG_CENTER_Y:    cy_reg <= cfg_data;
                REG_BIN_WIDTH:   bw_reg <= cfg_data[30:0];
                REG_BINS_IN_USE: nb_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Bin memories
    logic [CNT_W-1:0]        cnt_mem [MAX_BINS];
    logic signed [SUM_W-1:0] sum_mem [MAX_BINS];
    logic [CNT_W-1:0]        cnt_rd;
    logic signed [SUM_W-1:0] sum_rd;
    logic                    mem_we;
    logic [AW-1:0]           mem_wa, mem_ra;
    logic [CNT_W-1:0]        cnt_wd;
    logic signed [SUM_W-1:0] sum_wd;
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cnt_mem[mem_wa] <= cnt_wd;
            sum_mem[mem_wa] <= sum_wd;
        end
        cnt_rd <= cnt_mem[mem_ra];
        sum_rd <= sum_mem[mem_ra];
    end

    logic [3:0]  st_reg, st_next;
    logic [AW:0] idx_reg, idx_next;
    logic signed [31:0] z_reg, z_next;
    logic        last_reg, last_next;
    logic [65:0] s_reg, s_next;         // radicand
    logic [32:0] root_reg, root_next;
    logic [65:0] rem_reg, rem_next;
    logic [5:0]  sq_reg, sq_next;
    logic [63:0] k_reg, k_next;
    logic        neg_reg, neg_next;
    rpa_out_t    pend_reg, pend_next;
    logic        pend_v_reg, pend_v_next;
    rpa_out_t    out_reg, out_next;
    logic        ov_reg, ov_next;
    logic [CNT_W-1:0] c_hold_reg, c_hold_next;

    // Square of a difference (33-bit magnitude, registered once)
    logic signed [32:0] dx, dy;
    logic [32:0] ax, ay;
    assign dx = 33'(s_data.node_x) - 33'(cx_reg);
    assign dy = 33'(s_data.node_y) - 33'(cy_reg);
    assign ax = dx[32] ? 33'(-dx) : 33'(dx);
    assign ay = dy[32] ? 33'(-dy) : 33'(dy);

    // Divider
    logic        div_start, div_busy, div_done;
    logic [63:0] d_a, d_b, d_q;
    rpa_div #(.W(64)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(d_a), .divisor(d_b), .quotient(d_q),
        .busy(div_busy), .done(div_done)
    );

    logic [63:0] wq;
    logic [66:0] trial;
    logic [63:0] sabs;
    logic [6:0]  nbe;
    logic        room;
    logic signed [63:0] mean;
    assign wq = (bw_reg == '0) ? 64'd1 : 64'(bw_reg);
    assign nbe = (nb_reg > MAXB7) ? MAXB7 : nb_reg;
    assign sabs = sum_rd[SUM_W-1] ? 64'(-sum_rd) : 64'(sum_rd);
    assign mean = neg_reg ? -$signed(d_q) : $signed(d_q);

    always_comb begin
        st_next = st_reg; idx_next = idx_reg; z_next = z_reg; last_next = last_reg;
        s_next = s_reg; root_next = root_reg; rem_next = rem_reg; sq_next = sq_reg;
        k_next = k_reg; neg_next = neg_reg;
        pend_next = pend_reg; pend_v_next = pend_v_reg;
        out_next = out_reg; ov_next = ov_reg; c_hold_next = c_hold_reg;
        div_start = 1'b0; d_a = '0; d_b = wq;
        mem_we = 1'b0; mem_wa = idx_reg[AW-1:0]; mem_ra = idx_reg[AW-1:0];
        cnt_wd = '0; sum_wd = '0; trial = '0; room = 1'b0;
        s_ready = 1'b0;
        // Output register drains independently
        if (ov_reg && m_ready) ov_next = 1'b0;
        unique case (st_reg)
            ST_CLR: begin
                mem_we = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == (AW+1)'(MAX_BINS - 1)) st_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    s_next = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
                    z_next = s_data.node_z; last_next = s_data.last_node;
                    root_next = '0; rem_next = '0; sq_next = 6'd32;
                    st_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                // Digit-by-digit root, one bit per cycle
                trial = {rem_reg[64:0], s_reg[65:64]} - {32'd0, root_reg, 2'b01};
                if (!trial[66]) begin
                    rem_next = trial[65:0];
                    root_next = {root_reg[31:0], 1'b1};
                end else begin
                    rem_next = {rem_reg[63:0], s_reg[65:64]};
                    root_next = {root_reg[31:0], 1'b0};
                end
                s_next = {s_reg[63:0], 2'b00};
                sq_next = sq_reg - 1'b1;
                if (sq_reg == 6'd0) st_next = ST_DIVK;
            end
            ST_DIVK: begin
                div_start = 1'b1;
                d_a = {30'd0, root_reg, 1'b0} + wq;
                d_b = {wq[62:0], 1'b0};
                st_next = ST_WAITK;
            end
            ST_WAITK: begin
                if (div_done) begin
                    k_next = d_q;
                    mem_ra = d_q[AW-1:0];
                    st_next = ST_RD;
                end
            end
            ST_RD: begin
                mem_ra = k_reg[AW-1:0];
                st_next = ST_UPD;
            end
            ST_UPD: begin
                room = (k_reg < 64'(nbe)) && (cnt_rd != COUNT_MAX);
                mem_wa = k_reg[AW-1:0];
                if (room) begin
                    mem_we = 1'b1;
                    cnt_wd = cnt_rd + 1'b1;
                    sum_wd = sum_rd + SUM_W'(z_reg);
                end
                if (last_reg) begin
                    idx_next = '0; pend_v_next = 1'b0;
                    st_next = ST_SRD;
                end else st_next = ST_IDLE;
            end
            ST_SRD: begin
                st_next = ST_SCHK;
            end
            ST_SCHK: begin
                mem_we = 1'b1;        // clear entry as it is scanned
                if (cnt_rd != '0) begin
                    div_start = 1'b1;
                    d_a = sabs; d_b = 64'(cnt_rd);
                    neg_next = sum_rd[SUM_W-1];
                    c_hold_next = cnt_rd;
                    st_next = ST_SDIV;
                end else st_next = ST_SOUT;
            end
            ST_SDIV: begin
                // Quotient stays put once the divider goes idle
                if (!div_busy) begin
                    // Previous pending result goes out first
                    if (!pend_v_reg || !ov_reg || m_ready) begin
                        if (pend_v_reg) begin
                            out_next = pend_reg; ov_next = 1'b1;
                        end
                        pend_next.bin_index = 6'(idx_reg);
                        pend_next.node_count = c_hold_reg;
                        pend_next.mean_z = (mean < 64'(MEAN_FLOOR)) ? 32'sd0 : mean[31:0];
                        pend_next.last_bin = 1'b0;
                        pend_v_next = 1'b1;
                        st_next = ST_SOUT;
                    end
                end
            end
            ST_SOUT: begin
                if (idx_reg == (AW+1)'(MAX_BINS - 1)) begin
                    if (!pend_v_reg) st_next = ST_IDLE;
                    else if (!ov_reg || m_ready) begin
                        out_next = pend_reg; out_next.last_bin = 1'b1;
                        ov_next = 1'b1; pend_v_next = 1'b0;
                        st_next = ST_IDLE;
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                    mem_ra = AW'(idx_reg + 1'b1);
                    st_next = ST_SCHK;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    // State and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_CLR; idx_reg <= '0; ov_reg <= 1'b0; pend_v_reg <= 1'b0;
        end else begin
            st_reg <= st_next; idx_reg <= idx_next; ov_reg <= ov_next;
            pend_v_reg <= pend_v_next;
        end
        z_reg <= z_next; last_reg <= last_next; s_reg <= s_next;
        root_reg <= root_next; rem_reg <= rem_next; sq_reg <= sq_next;
        k_reg <= k_next; neg_reg <= neg_next; pend_reg <= pend_next;
        out_reg <= out_next; c_hold_reg <= c_hold_next;
    end

    assign m_valid = ov_reg;
    assign m_data = out_reg;

    `RPA_ASSERT_IMP(a_ready_idle, aclk, aresetn, s_ready, st_reg == ST_IDLE, "ready outside idle")
    `RPA_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result dropped")
    `RPA_ASSERT_IMP(a_start_idle, aclk, aresetn, div_start, !div_busy, "divider restarted while busy")
endmodule
